[hw/rtl/fpg_pkg.sv]
// ----------------------------------------------------------------------------
// fpg_pkg: shared definitions of the flow packet generator
// Generator constants, register indexes, default parameters and the LCG step.
// ----------------------------------------------------------------------------
package fpg_pkg;

  localparam int unsigned FLOW_COUNT_DEF = 8;
  localparam int unsigned MIN_LEN_DEF    = 64;
  localparam int unsigned LEN_MOD_DEF    = 8256;

  localparam int unsigned FLOW_ID_W = 10;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned LEN_W     = 14;
  localparam int unsigned LCG_W     = 64;
  localparam int unsigned PICK_SHIFT = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [17:0] LCG_MUL = 18'd214013;
  localparam logic [21:0] LCG_INC = 22'd2531011;

  // Generator value one step after the reset seed of 1.
  localparam logic [LCG_W-1:0] LCG_RESET_NEXT = 64'd2745024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOW_SEED = 2'd0,
    CFG_LEN_SEED  = 2'd1,
    CFG_FLOW_BASE = 2'd2
  } cfg_idx_e;

  // One LCG step modulo 2^64, built from two 32 x 18 bit products.
  function automatic logic [LCG_W-1:0] lcg_next(input logic [LCG_W-1:0] x);
    logic [49:0] lo_prod;
    logic [49:0] hi_prod;
    logic [LCG_W-1:0] sum;
    lo_prod = {18'b0, x[31:0]} * {32'b0, LCG_MUL};
    hi_prod = {18'b0, x[63:32]} * {32'b0, LCG_MUL};
    sum = {hi_prod[31:0], 32'b0} + {14'b0, lo_prod} + {42'b0, LCG_INC};
    return sum;
  endfunction

endpackage

[hw/rtl/flow_packet_generator.sv]
// ----------------------------------------------------------------------------
// flow_packet_generator: test traffic header generator
// Emits one header word per go request: flow number, per-flow order number and
// a pseudo-random payload length drawn from two 64-bit LCGs.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the header stream is not stalled; the
// four-stage length reduction pipeline (byte folding, reciprocal multiply,
// remainder correction) sets the latency.
// Reset clears the flow counters and loads both generators with seed 1 at
// once; no clearing pass is needed.
module flow_packet_generator #(
  parameter int unsigned FLOW_COUNT = fpg_pkg::FLOW_COUNT_DEF,
  parameter int unsigned MIN_LEN    = fpg_pkg::MIN_LEN_DEF,
  parameter int unsigned LEN_MOD    = fpg_pkg::LEN_MOD_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fpg_pkg::LCG_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // go
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [55:0]                     m_axis_tdata   // flow_id, seq_number, pkt_length
);
  import fpg_pkg::*;

  localparam int unsigned PICK_W = $clog2(FLOW_COUNT);
  localparam int unsigned SPAN   = (LEN_MOD > MIN_LEN) ? (LEN_MOD - MIN_LEN) : 1;
  localparam int unsigned SPAN_W = $clog2(SPAN + 1);
  localparam int unsigned Y_W    = SPAN_W + 11;
  localparam int unsigned REM_W  = SPAN_W + 1;
  localparam int unsigned X_W    = LCG_W - PICK_SHIFT;
  localparam int unsigned TERM_W = SPAN_W + 8;

  localparam logic [PICK_W-1:0] PICK_MASK = PICK_W'(FLOW_COUNT - 1);
  localparam logic [Y_W:0]      RECIP     = (Y_W + 1)'((64'd1 << Y_W) / SPAN);
  localparam logic [REM_W-1:0]  SPAN_C    = REM_W'(SPAN);

  localparam logic [SPAN_W-1:0] BYTE_MOD [6] = '{
    SPAN_W'((64'd1 <<  0) % SPAN),
    SPAN_W'((64'd1 <<  8) % SPAN),
    SPAN_W'((64'd1 << 16) % SPAN),
    SPAN_W'((64'd1 << 24) % SPAN),
    SPAN_W'((64'd1 << 32) % SPAN),
    SPAN_W'((64'd1 << 40) % SPAN)
  };

  logic [LCG_W-1:0]     flow_p_q, flow_p_d;
  logic [LCG_W-1:0]     len_p_q, len_p_d;
  logic [FLOW_ID_W-1:0] flow_base_q;
  logic [SEQ_W-1:0]     cnt_q [FLOW_COUNT];

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic                 rdy1, rdy2, rdy3, rdy4;
  logic                 accept, take;
  logic [PICK_W-1:0]    pick;
  logic [SEQ_W-1:0]     seq_rd;
  logic [FLOW_ID_W-1:0] flow_sum;

  logic [FLOW_ID_W-1:0] flow1_q, flow2_q, flow3_q, flow4_q;
  logic [SEQ_W-1:0]     seq1_q, seq2_q, seq3_q, seq4_q;
  logic [X_W-1:0]       x1_q;
  logic [Y_W-1:0]       y2_q, y3_q, y_fold;
  logic [Y_W-1:0]       q3_q, q_est;
  logic [2*Y_W:0]       recip_prod;
  logic [2*REM_W-1:0]   qs_prod;
  logic [REM_W-1:0]     rem_raw, rem;
  logic [17:0]          len_sum;
  logic [LEN_W-1:0]     len4_q;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign take   = accept && s_axis_tdata[0];

  assign pick     = flow_p_q[PICK_SHIFT +: PICK_W] & PICK_MASK;
  assign seq_rd   = cnt_q[pick];
  assign flow_sum = flow_base_q + FLOW_ID_W'(pick);

  always_comb begin
    flow_p_d = flow_p_q;
    len_p_d  = len_p_q;
    if (cfg_we_i && (cfg_idx_i == CFG_FLOW_SEED)) begin
      flow_p_d = lcg_next(cfg_wdata_i);
    end else if (take) begin
      flow_p_d = lcg_next(flow_p_q);
    end
    if (cfg_we_i && (cfg_idx_i == CFG_LEN_SEED)) begin
      len_p_d = lcg_next(cfg_wdata_i);
    end else if (take) begin
      len_p_d = lcg_next(len_p_q);
    end
  end

  always_comb begin
    logic [TERM_W-1:0] term;
    y_fold = '0;
    for (int i = 0; i < 6; i++) begin
      term   = TERM_W'(x1_q[8*i +: 8]) * TERM_W'(BYTE_MOD[i]);
      y_fold = y_fold + Y_W'(term);
    end
  end

  assign recip_prod = (2*Y_W + 1)'(y2_q) * (2*Y_W + 1)'(RECIP);
  assign q_est      = recip_prod[Y_W +: Y_W];

  assign qs_prod = (2*REM_W)'(q3_q[REM_W-1:0]) * (2*REM_W)'(SPAN_C);
  assign rem_raw = y3_q[REM_W-1:0] - qs_prod[REM_W-1:0];
  assign rem     = (rem_raw >= SPAN_C) ? (rem_raw - SPAN_C) : rem_raw;
  assign len_sum = 18'(rem) + 18'(MIN_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_p_q    <= LCG_RESET_NEXT;
      len_p_q     <= LCG_RESET_NEXT;
      flow_base_q <= '0;
      for (int i = 0; i < FLOW_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      flow_p_q <= flow_p_d;
      len_p_q  <= len_p_d;
      if (cfg_we_i && (cfg_idx_i == CFG_FLOW_BASE)) begin
        flow_base_q <= cfg_wdata_i[FLOW_ID_W-1:0];
      end
      if (take) begin
        cnt_q[pick] <= seq_rd + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= take;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      flow1_q <= flow_sum;
      seq1_q  <= seq_rd;
      x1_q    <= len_p_q[PICK_SHIFT +: X_W];
    end
    if (v1_q && rdy2) begin
      flow2_q <= flow1_q;
      seq2_q  <= seq1_q;
      y2_q    <= y_fold;
    end
    if (v2_q && rdy3) begin
      flow3_q <= flow2_q;
      seq3_q  <= seq2_q;
      y3_q    <= y2_q;
      q3_q    <= q_est;
    end
    if (v3_q && rdy4) begin
      flow4_q <= flow3_q;
      seq4_q  <= seq3_q;
      len4_q  <= len_sum[LEN_W-1:0];
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {len4_q, seq4_q, flow4_q};

endmodule

[hw/rtl/fpg_checker.sv]
// ----------------------------------------------------------------------------
// fpg_checker: port-level checks of the flow packet generator
// Watches the stream ports for stall behavior and header word ranges.
// ----------------------------------------------------------------------------
module fpg_checker #(
  parameter int unsigned MIN_LEN = fpg_pkg::MIN_LEN_DEF,
  parameter int unsigned LEN_MOD = fpg_pkg::LEN_MOD_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata   // flow_id, seq_number, pkt_length
);
  import fpg_pkg::*;

  localparam int unsigned SPAN   = (LEN_MOD > MIN_LEN) ? (LEN_MOD - MIN_LEN) : 1;
  localparam int unsigned LEN_HI = MIN_LEN + SPAN - 1;
  localparam logic        LEN_FITS = (LEN_HI < 16384);

  logic [31:0] len_word;
  assign len_word = {18'b0, m_axis_tdata[55:42]};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Header word dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("Header word changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("Request side blocked without a stalled header word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && LEN_FITS |-> (len_word >= MIN_LEN) && (len_word <= LEN_HI))
    else $error("Packet length out of range.");

endmodule

bind flow_packet_generator fpg_checker #(
  .MIN_LEN(MIN_LEN),
  .LEN_MOD(LEN_MOD)
) u_fpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[bench/flow_header_checker.sv]
// ----------------------------------------------------------------------------
// flow_header_checker: header word checker for the flow packet generator
// Watches the register port and both streams, keeps its own copy of the two
// generators, the flow base and the per-flow order counters, predicts one
// header word for every accepted go request word and compares each header word
// that leaves the block with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module flow_header_checker
  import fpg_pkg::*;
#(
  parameter int unsigned FLOW_COUNT = FLOW_COUNT_DEF,
  parameter int unsigned MIN_LEN    = MIN_LEN_DEF,
  parameter int unsigned LEN_MOD    = LEN_MOD_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LCG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // go
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [55:0]          m_axis_tdata,  // flow_id, seq_number, pkt_length
  output int                   outstanding_o,
  output int                   mismatches_o
);

  localparam int unsigned LEN_SPAN  = (LEN_MOD > MIN_LEN) ? LEN_MOD - MIN_LEN : 1;
  localparam int unsigned MAX_SHOWN = 10;

  // The first member sits in the highest bits, so flow_id lands in the lowest.
  typedef struct packed {
    logic [LEN_W-1:0]     pkt_length;
    logic [SEQ_W-1:0]     seq_number;
    logic [FLOW_ID_W-1:0] flow_id;
  } header_t;

  logic [LCG_W-1:0]     flow_state;
  logic [LCG_W-1:0]     len_state;
  logic [FLOW_ID_W-1:0] base;
  logic [SEQ_W-1:0]     seq_count [FLOW_COUNT];
  header_t              header_q [$];
  int                   mismatches = 0;

  function automatic header_t predict_header();
    logic [LCG_W-1:0] drawn;
    int unsigned      pick;
    header_t          hdr;
    flow_state = flow_state * LCG_W'(LCG_MUL) + LCG_W'(LCG_INC);
    drawn = flow_state >> PICK_SHIFT;
    pick = 32'((drawn & LCG_W'(FLOW_COUNT - 1)) % FLOW_COUNT);
    len_state = len_state * LCG_W'(LCG_MUL) + LCG_W'(LCG_INC);
    drawn = len_state >> PICK_SHIFT;
    hdr.pkt_length = LEN_W'((drawn % LEN_SPAN) + MIN_LEN);
    hdr.seq_number = seq_count[pick];
    seq_count[pick] = seq_count[pick] + 1'b1;
    hdr.flow_id = FLOW_ID_W'(pick + base);
    return hdr;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    header_t got;
    header_t want;
    if (!rst_ni) begin
      flow_state = 64'd1;
      len_state = 64'd1;
      base = '0;
      foreach (seq_count[i]) seq_count[i] = '0;
      header_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FLOW_SEED: flow_state = cfg_wdata_i;
          CFG_LEN_SEED:  len_state = cfg_wdata_i;
          CFG_FLOW_BASE: base = cfg_wdata_i[FLOW_ID_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = header_t'(m_axis_tdata);
        if (header_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("Header word with none expected: flow %0d seq %0d length %0d",
                     got.flow_id, got.seq_number, got.pkt_length);
          end
        end else begin
          want = header_q.pop_front();
          if (got.flow_id !== want.flow_id || got.seq_number !== want.seq_number ||
              got.pkt_length !== want.pkt_length) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("Mismatch: exp flow %0d seq %0d len %0d, got flow %0d seq %0d len %0d",
                       want.flow_id, want.seq_number, want.pkt_length,
                       got.flow_id, got.seq_number, got.pkt_length);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready && s_axis_tdata[0]) begin
        header_q.push_back(predict_header());
      end
      outstanding_o <= int'(header_q.size());
    end
  end

  assign mismatches_o = mismatches;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the flow packet generator
// Drives request words and register writes, stalls both streams in random
// bursts, holds the header stream off once for a long stretch, and gives the
// verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module tb_top;
  import fpg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 128;
  localparam int unsigned HOLD_PHASE  = 3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [LCG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [55:0]          m_axis_tdata;

  int   outstanding;
  int   mismatches;
  int   quiet_cycles = 0;
  logic tx_gaps_on = 1'b1;
  logic rx_gaps_on = 1'b1;
  logic hold_req = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  flow_packet_generator DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  flow_header_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .outstanding_o(outstanding), .mismatches_o(mismatches)
  );

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : header_sink
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (rx_gaps_on ? $urandom_range(1, 12) : 1) @(posedge clk_i);
      end
    end
  end

  // Seed whose next generator value is the given one.
  function automatic logic [LCG_W-1:0] seed_before(input logic [LCG_W-1:0] target);
    logic [LCG_W-1:0] inv;
    inv = LCG_W'(LCG_MUL);
    repeat (6) inv = inv * (64'd2 - LCG_W'(LCG_MUL) * inv);
    return (target - LCG_W'(LCG_INC)) * inv;
  endfunction

  task automatic send_request(input logic go);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, go};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic maybe_pause();
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LCG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [3:0] sel, input logic [LCG_W-1:0] fseed,
                           input logic [LCG_W-1:0] lseed, input logic [FLOW_ID_W-1:0] base);
    if (sel[CFG_FLOW_SEED]) write_reg(CFG_FLOW_SEED, fseed);
    if (sel[CFG_LEN_SEED]) write_reg(CFG_LEN_SEED, lseed);
    if (sel[CFG_FLOW_BASE]) write_reg(CFG_FLOW_BASE, LCG_W'(base));
    if (sel[CFG_UNUSED]) write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_burst(input int unsigned count);
    int unsigned sent;
    logic go;
    sent = 0;
    while (sent < count) begin
      go = ($urandom_range(0, 9) != 0);
      send_request(go);
      if (go) sent++;
      maybe_pause();
    end
  endtask

  initial begin : stimulus
    logic [LCG_W-1:0]     fseed;
    logic [LCG_W-1:0]     lseed;
    logic [FLOW_ID_W-1:0] base;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Generators and counters straight out of reset, with an idle request.
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);

    settle();
    configure(4'b1111, '0, '0, '0);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b1);

    settle();
    configure(4'b0111, '1, '1, 10'd1016);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);

    // Highest flow pick on the highest base, and the longest length.
    settle();
    fseed = {$urandom, $urandom};
    fseed[18:16] = 3'b111;
    lseed = {$urandom, $urandom};
    lseed[28:16] = '1;
    configure(4'b0011, seed_before(fseed), seed_before(lseed), '0);
    send_request(1'b1);

    // Lowest flow pick and the shortest length.
    settle();
    fseed = {$urandom, $urandom};
    fseed[18:16] = '0;
    lseed = {$urandom, $urandom};
    lseed[28:16] = '0;
    configure(4'b0011, seed_before(fseed), seed_before(lseed), '0);
    send_request(1'b1);

    // A write to the unused index must leave everything as it was.
    settle();
    configure(4'b1000, '0, '0, '0);
    send_request(1'b1);
    send_request(1'b1);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      settle();
      fseed = {$urandom, $urandom};
      lseed = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: fseed = '0;
        1: lseed = '1;
        2: fseed = '1;
        default: ;
      endcase
      case (phase % 3)
        0: base = FLOW_ID_W'($urandom_range(0, 1016));
        1: base = 10'd1016;
        default: base = '0;
      endcase
      configure(4'($urandom_range(1, 15)), fseed, lseed, base);
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      if (phase == PHASES - 1) begin
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
      end
      send_burst(PHASE_ITEMS);
    end

    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
